[rtl/swct_pkg.sv]
`default_nettype none
package swct_pkg;
  localparam int KEY_W = 64;
  localparam int SONG_W = 16;
  localparam int CNT_W = 16;
  localparam int TOT_W = 32;
  localparam int STAT_W = 3;

  localparam logic [STAT_W-1:0] ST_UPDATED  = 3'd0;
  localparam logic [STAT_W-1:0] ST_INSERTED = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STAT_W-1:0] ST_HIT      = 3'd3;
  localparam logic [STAT_W-1:0] ST_MISS     = 3'd4;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PROBE,
    S_CHECK,
    S_FINAL,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_WRITE,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [TOT_W-1:0]  total;
    logic [SONG_W-1:0] song;
    logic [CNT_W-1:0]  best;
  } entry_t;
endpackage
`default_nettype wire

[rtl/sorted_word_count_table_core.sv]
`default_nettype none
// Sorted keyed count table held in one synchronous memory (one read port,
// one write port) of TABLE_DEPTH entries (key, saturating total, best song,
// best count). Each item runs a binary search of about log2(entry count)
// probes, and every probe waits on the memory read. A new word also shifts
// every entry above its position up by one, each move a read and then a
// write through the memory. One item is in work at a time; the result waits
// in an output register and the next item is taken once it has been
// delivered. No clearing pass is needed after reset.
module sorted_word_count_table_core #(
  parameter int TABLE_DEPTH = 256
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire                          in_command,
  input  wire  [swct_pkg::KEY_W-1:0]   in_word_key,
  input  wire  [swct_pkg::SONG_W-1:0]  in_song_id,
  input  wire  [swct_pkg::CNT_W-1:0]   in_count,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [swct_pkg::STAT_W-1:0]  out_status,
  output logic [swct_pkg::TOT_W-1:0]   out_total_count,
  output logic [swct_pkg::SONG_W-1:0]  out_best_song,
  output logic [swct_pkg::CNT_W-1:0]   out_best_count
);
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  swct_pkg::state_t state_r, state_nxt;

  // table memory
  swct_pkg::entry_t mem [TABLE_DEPTH];
  swct_pkg::entry_t rd_q;
  logic          mem_we;
  logic [AW-1:0] mem_wa, mem_ra;
  swct_pkg::entry_t mem_wd;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_q <= mem[mem_ra];
  end

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] lo_r, lo_nxt, hi_r, hi_nxt, idx_r, idx_nxt;
  logic          cmd_r;
  logic [swct_pkg::KEY_W-1:0]  key_r;
  logic [swct_pkg::SONG_W-1:0] song_r;
  logic [swct_pkg::CNT_W-1:0]  cnt_in_r;
  logic [swct_pkg::STAT_W-1:0] stat_r, stat_nxt;
  swct_pkg::entry_t res_r, res_nxt;
  logic          ov_r, ov_nxt;

  logic [CW-1:0] mid;
  logic [swct_pkg::TOT_W:0] sum;
  logic [swct_pkg::TOT_W-1:0] sat_sum;
  logic found;

  assign mid = lo_r + ((hi_r - lo_r) >> 1);
  assign found = (lo_r < cnt_r) && (rd_q.key == key_r);
  assign sum = {1'b0, rd_q.total} + {{(swct_pkg::TOT_W-swct_pkg::CNT_W+1){1'b0}}, cnt_in_r};
  assign sat_sum = sum[swct_pkg::TOT_W] ? '1 : sum[swct_pkg::TOT_W-1:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      swct_pkg::S_IDLE:
        if (in_valid && in_ready) begin
          state_nxt = swct_pkg::S_PROBE;
        end
      swct_pkg::S_PROBE:
        if (lo_r < hi_r) begin
          state_nxt = swct_pkg::S_CHECK;
        end else begin
          state_nxt = swct_pkg::S_FINAL;
        end
      swct_pkg::S_CHECK: state_nxt = swct_pkg::S_PROBE;
      swct_pkg::S_FINAL: begin
        if (found || cmd_r == swct_pkg::CMD_LOOKUP || cnt_r >= DEPTH_C) begin
          state_nxt = swct_pkg::S_OUT;
        end else if (cnt_r > lo_r) begin
          state_nxt = swct_pkg::S_SHIFT_WR;
        end else begin
          state_nxt = swct_pkg::S_WRITE;
        end
      end
      swct_pkg::S_SHIFT_RD: state_nxt = swct_pkg::S_SHIFT_WR;
      swct_pkg::S_SHIFT_WR:
        if (idx_r - 1'b1 > lo_r) begin
          state_nxt = swct_pkg::S_SHIFT_RD;
        end else begin
          state_nxt = swct_pkg::S_WRITE;
        end
      swct_pkg::S_WRITE: state_nxt = swct_pkg::S_OUT;
      swct_pkg::S_OUT: state_nxt = swct_pkg::S_IDLE;
      default: state_nxt = swct_pkg::S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    idx_nxt = idx_r;
    cnt_nxt = cnt_r;
    stat_nxt = stat_r;
    res_nxt = res_r;
    ov_nxt = ov_r;
    mem_we = 1'b0;
    mem_wa = idx_r[AW-1:0];
    mem_wd = res_r;
    mem_ra = mid[AW-1:0];
    in_ready = (state_r == swct_pkg::S_IDLE) && !ov_r;
    if (ov_r && out_ready) begin
      ov_nxt = 1'b0;
    end
    case (state_r)
      swct_pkg::S_IDLE:
        if (in_valid && in_ready) begin
          lo_nxt = '0;
          hi_nxt = cnt_r;
        end
      swct_pkg::S_PROBE:
        // with lo == hi the read address is lo for the final match check
        mem_ra = (lo_r < hi_r) ? mid[AW-1:0] : lo_r[AW-1:0];
      swct_pkg::S_CHECK:
        if (rd_q.key < key_r) begin
          lo_nxt = mid + 1'b1;
        end else begin
          hi_nxt = mid;
        end
      swct_pkg::S_FINAL: begin
        idx_nxt = cnt_r;
        mem_ra = cnt_r[AW-1:0] - 1'b1;
        if (cmd_r == swct_pkg::CMD_LOOKUP) begin
          stat_nxt = found ? swct_pkg::ST_HIT : swct_pkg::ST_MISS;
          res_nxt = found ? rd_q : '0;
        end else if (found) begin
          res_nxt = rd_q;
          res_nxt.total = sat_sum;
          if (cnt_in_r > rd_q.best) begin
            res_nxt.best = cnt_in_r;
            res_nxt.song = song_r;
          end
          stat_nxt = swct_pkg::ST_UPDATED;
          mem_we = 1'b1;
          mem_wa = lo_r[AW-1:0];
          mem_wd = res_nxt;
        end else if (cnt_r >= DEPTH_C) begin
          stat_nxt = swct_pkg::ST_FULL;
          res_nxt = '0;
        end else begin
          stat_nxt = swct_pkg::ST_INSERTED;
          res_nxt.key = key_r;
          res_nxt.total = {{(swct_pkg::TOT_W-swct_pkg::CNT_W){1'b0}}, cnt_in_r};
          res_nxt.song = song_r;
          res_nxt.best = cnt_in_r;
        end
      end
      swct_pkg::S_SHIFT_RD:
        mem_ra = idx_r[AW-1:0] - 1'b1;
      swct_pkg::S_SHIFT_WR: begin
        // move entry idx-1 up to idx
        mem_we = 1'b1;
        mem_wa = idx_r[AW-1:0];
        mem_wd = rd_q;
        idx_nxt = idx_r - 1'b1;
      end
      swct_pkg::S_WRITE: begin
        mem_we = 1'b1;
        mem_wa = lo_r[AW-1:0];
        mem_wd = res_r;
        cnt_nxt = cnt_r + 1'b1;
      end
      swct_pkg::S_OUT:
        ov_nxt = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= swct_pkg::S_IDLE;
      cnt_r <= '0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      ov_r <= ov_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
    idx_r <= idx_nxt;
    stat_r <= stat_nxt;
    res_r <= res_nxt;
    if (in_valid && in_ready) begin
      cmd_r <= in_command;
      key_r <= in_word_key;
      song_r <= in_song_id;
      cnt_in_r <= in_count;
    end
  end

  assign out_valid = ov_r;
  assign out_status = stat_r;
  assign out_total_count = res_r.total;
  assign out_best_song = res_r.song;
  assign out_best_count = res_r.best;
endmodule
`default_nettype wire

[rtl/swct_checker.sv]
`default_nettype none
module swct_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_valid,
  input wire        in_ready,
  input wire        out_valid,
  input wire        out_ready,
  input wire [2:0]  out_status,
  input wire [31:0] out_total_count,
  input wire [15:0] out_best_song,
  input wire [15:0] out_best_count
);
  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)) else $error("result dropped");
  // no new item while a result waits
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("item taken while result pending");
  // miss and drop report zeros
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == swct_pkg::ST_FULL || out_status == swct_pkg::ST_MISS) |->
    out_total_count == 0 && out_best_song == 0 && out_best_count == 0)
    else $error("nonzero payload on miss");
  // status code in range
  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= swct_pkg::ST_MISS) else $error("bad status");
  // a result does not appear right after an item is taken
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !out_valid ##1 !out_valid) else $error("result too early");
endmodule

bind sorted_word_count_table_core swct_checker u_swct_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
  .out_total_count(out_total_count), .out_best_song(out_best_song),
  .out_best_count(out_best_count)
);
`default_nettype wire
